// File: rtl/bellman_ford_negative_cycle_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef BELLMAN_FORD_NEGATIVE_CYCLE_DEFINES_SVH
`define BELLMAN_FORD_NEGATIVE_CYCLE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define BFNC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BFNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bfnc_pkg.sv
package bfnc_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_WEIGHT_BITS  = 16;
  localparam int DIST_W           = 32;

  // Transaction function codes.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN_INIT,
    ST_ROW_START,
    ST_ROW_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              relax;
    logic [DIST_W-1:0] cand;
  } relax_t;

endpackage

// File: rtl/bellman_ford_negative_cycle.sv
// Negative-cycle detector over a directed graph held as an adjacency matrix.
// Input channel (in_valid/in_ready): in_func selects clear all edges, write
// one edge (in_edge_from, in_edge_to, in_edge_weight; zero removes it) or run
// detection from cfg source_vertex over the first cfg vertex_count vertices.
// Only a run gives a result transaction on out_valid/out_ready, carrying
// out_negative_cycle. in_ready is high only while the block is idle.
// A clear sweeps the whole weight memory of MAX_VERTICES*MAX_VERTICES entries
// (4096 by default). A run takes n passes over the matrix, n being the
// vertex count; each pass walks every reached row and skips an unreached
// row. The weight memory read port delivers one entry per cycle. After
// reset the block runs the same clearing pass before it takes its first
// transaction; configuration writes are taken at any time.
// A finished result waits in the output register while out_ready is low.
// The block still takes transactions meanwhile, but a run that ends before
// the register is free holds in_ready low until the result has been taken.
module bellman_ford_negative_cycle import bfnc_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_edge_from,
  input  logic [5:0]         in_edge_to,
  input  logic signed [15:0] in_edge_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_negative_cycle,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);

`include "bellman_ford_negative_cycle_defines.svh"

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = VW + 1;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

  state_t            state_r, state_nxt;
  logic [6:0]        vcount_r;
  logic [5:0]        src_r;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_nc_r, out_nc_nxt;
  logic              cyc_r, cyc_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [VW-1:0]     i_r, i_nxt;
  logic [VW-1:0]     jp_r, jp_nxt;
  logic [VW-1:0]     pass_r, pass_nxt;
  logic signed [DIST_W-1:0] di_r, di_nxt;

  logic [NW-1:0]     n_act;
  logic [NW-1:0]     n_last;
  logic              last_pass, last_row, last_col, src_ok, row_done;
  logic [VW-1:0]     rd_col, e_from, e_to;
  logic              edge_ok;
  logic signed [32:0] w_ext;
  logic [WEIGHT_BITS-1:0] w_clamped;

  logic                   w_we;
  logic [AW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic                   d_we;
  logic [VW-1:0]          d_waddr, d_raddr;
  logic [DIST_W-1:0]      d_wdata, d_rdata;
  relax_t                 rlx;

  bfnc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  bfnc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  bfnc_relax #(.WEIGHT_BITS(WEIGHT_BITS)) u_relax (
    .dist_tail    (di_r),
    .weight       ($signed(w_rdata)),
    .dist_head    ($signed(d_rdata)),
    .head_reached (reached_r[jp_r]),
    .res          (rlx)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd1;
      src_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vcount_r <= cfg_wdata;
        CFG_SOURCE_VERTEX: src_r    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcount_r == '0) begin
      n_act = NW'(1);
    end else if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(vcount_r);
    end
  end

  always_comb begin
    w_ext = 33'(in_edge_weight);
    if (w_ext > W_HI) begin
      w_clamped = W_HI[WEIGHT_BITS-1:0];
    end else if (w_ext < W_LO) begin
      w_clamped = W_LO[WEIGHT_BITS-1:0];
    end else begin
      w_clamped = w_ext[WEIGHT_BITS-1:0];
    end
  end

  assign e_from    = VW'(in_edge_from);
  assign e_to      = VW'(in_edge_to);
  assign edge_ok   = (32'(in_edge_from) < 32'(MAX_VERTICES)) &&
                     (32'(in_edge_to) < 32'(MAX_VERTICES));
  assign n_last    = n_r - NW'(1);
  assign last_pass = ({1'b0, pass_r} == n_last);
  assign last_row  = ({1'b0, i_r} == n_last);
  assign last_col  = ({1'b0, jp_r} == n_last);
  assign src_ok    = (32'(src_r) < 32'(n_r));
  assign rd_col    = (state_r == ST_SCAN) ? (jp_r + VW'(1)) : '0;
  assign w_raddr   = AW'(i_r) * AW'(MAX_VERTICES) + AW'(rd_col);
  assign d_raddr   = (state_r == ST_ROW_START) ? i_r : rd_col;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    reached_nxt   = reached_r;
    out_valid_nxt = out_valid_r;
    out_nc_nxt    = out_nc_r;
    cyc_nxt       = cyc_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    jp_nxt        = jp_r;
    pass_nxt      = pass_r;
    di_nxt        = di_r;
    in_ready      = 1'b0;
    row_done      = 1'b0;
    w_we          = 1'b0;
    w_waddr       = clr_cnt_r;
    w_wdata       = '0;
    d_we          = 1'b0;
    d_waddr       = jp_r;
    d_wdata       = rlx.cand;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        w_we = 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            FUNC_EDGE: begin
              w_we    = edge_ok;
              w_waddr = AW'(e_from) * AW'(MAX_VERTICES) + AW'(e_to);
              w_wdata = w_clamped;
            end
            FUNC_RUN: begin
              n_nxt     = n_act;
              state_nxt = ST_RUN_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_RUN_INIT: begin
        reached_nxt = '0;
        cyc_nxt     = 1'b0;
        i_nxt       = '0;
        pass_nxt    = '0;
        if (src_ok) begin
          d_we                   = 1'b1;
          d_waddr                = VW'(src_r);
          d_wdata                = '0;
          reached_nxt[VW'(src_r)] = 1'b1;
          state_nxt              = ST_ROW_START;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ROW_START: begin
        // Rows whose tail is unreached contribute nothing in this pass.
        if (reached_r[i_r]) begin
          state_nxt = ST_ROW_LOAD;
        end else begin
          row_done = 1'b1;
        end
      end
      ST_ROW_LOAD: begin
        di_nxt    = $signed(d_rdata);
        jp_nxt    = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rlx.relax) begin
          if (last_pass) begin
            cyc_nxt = 1'b1;
          end else begin
            d_we              = 1'b1;
            reached_nxt[jp_r] = 1'b1;
            // A self-loop moves the tail distance used by the rest of the row.
            if (jp_r == i_r) begin
              di_nxt = $signed(rlx.cand);
            end
          end
        end
        if (last_col) begin
          row_done = 1'b1;
        end else begin
          jp_nxt = jp_r + VW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nc_nxt    = cyc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (row_done) begin
      if (!last_row) begin
        i_nxt     = i_r + VW'(1);
        state_nxt = ST_ROW_START;
      end else if (last_pass) begin
        state_nxt = ST_DONE;
      end else begin
        i_nxt     = '0;
        pass_nxt  = pass_r + VW'(1);
        state_nxt = ST_ROW_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      reached_r   <= '0;
      out_valid_r <= 1'b0;
      cyc_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      reached_r   <= reached_nxt;
      out_valid_r <= out_valid_nxt;
      cyc_r       <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_nc_r <= out_nc_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    jp_r     <= jp_nxt;
    pass_r   <= pass_nxt;
    di_r     <= di_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_negative_cycle = out_nc_r;

  `BFNC_ASSERT_NEXT(a_run_starts, in_valid && in_ready && in_func == FUNC_RUN, state_r == ST_RUN_INIT, "run transaction did not start a run")
  `BFNC_ASSERT_NEXT(a_init_single_reach, state_r == ST_RUN_INIT, $countones(reached_r) <= 1, "more than the source reached at run start")
  `BFNC_ASSERT_SAME(a_check_pass_read_only, state_r == ST_SCAN && last_pass, !d_we, "distance written during the checking pass")
  `BFNC_ASSERT_SAME(a_weight_write_idle, w_we, state_r == ST_CLEAR || state_r == ST_IDLE, "weight memory written during a run")

endmodule

// File: rtl/bfnc_ram.sv
module bfnc_ram import bfnc_pkg::*; #(
  parameter int WIDTH = DEF_WEIGHT_BITS,
  parameter int DEPTH = DEF_MAX_VERTICES
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bfnc_relax.sv
module bfnc_relax import bfnc_pkg::*; #(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic signed [DIST_W-1:0]      dist_tail,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  input  logic signed [DIST_W-1:0]      dist_head,
  input  logic                          head_reached,
  output relax_t                        res
);

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  always_comb begin
    sum = (DIST_W+1)'(dist_tail) + (DIST_W+1)'(weight);
    // Saturate when the top two bits of the sum disagree.
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
    res.cand  = cand;
    res.relax = (weight != '0) && (!head_reached || (cand < dist_head));
  end

endmodule
